// ===== hw/rtl/swe_pkg.sv =====
// ----------------------------------------------------------------------------
// swe_pkg - shared types, constants and helpers of the stereo width enhancer
// Fixed-point widths, configuration indexes, datapath op codes and the
// coefficient conversion functions.
// ----------------------------------------------------------------------------
package swe_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int STATE_BITS  = 32;
    localparam int FRAC_RAW    = (STATE_BITS > SAMPLE_BITS) ? (STATE_BITS - SAMPLE_BITS) : 0;
    localparam int FRAC        = (FRAC_RAW > 8) ? 8 : FRAC_RAW;

    localparam int Q_SHIFT    = 16;
    localparam int GAIN_SHIFT = 13;
    localparam int COEF_W     = 18;
    localparam int GAIN_W     = 16;
    localparam int PCT_W      = 8;

    localparam int MUL_B_W = COEF_W + 1;
    localparam int ACC_W   = STATE_BITS + 1 + COEF_W + 1;
    localparam int MUL_A_W = ACC_W - Q_SHIFT;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = MUL_P_W + 1;
    localparam int SAT_W   = MUL_P_W - GAIN_SHIFT;
    localparam int UPD_W   = MUL_P_W - Q_SHIFT + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENHANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOCUS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WET     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MONO    = 3'd7;

    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << Q_SHIFT;
    localparam logic [6:0]        WET_MAX  = 7'd100;

    localparam logic [22:0] RECIP_25  = 23'd5368710;
    localparam logic [24:0] RECIP_125 = 25'd17179870;

    typedef logic [3:0] op_t;

    localparam op_t OP_NONE = 4'd0;
    localparam op_t OP_DIFF = 4'd1;
    localparam op_t OP_UPD  = 4'd2;
    localparam op_t OP_HP   = 4'd3;
    localparam op_t OP_ACC  = 4'd4;
    localparam op_t OP_SCL  = 4'd5;
    localparam op_t OP_SIDE = 4'd6;
    localparam op_t OP_MIXR = 4'd7;
    localparam op_t OP_WL   = 4'd8;
    localparam op_t OP_WR   = 4'd9;
    localparam op_t OP_GL   = 4'd10;
    localparam op_t OP_GR   = 4'd11;
    localparam op_t OP_MMUL = 4'd12;
    localparam op_t OP_MSAT = 4'd13;

    typedef struct packed {
        logic [COEF_W-1:0] width_q;
        logic [COEF_W-1:0] enhance_q;
        logic [COEF_W-1:0] smooth_q;
        logic [COEF_W-1:0] bass_q;
        logic [COEF_W-1:0] wet_q;
        logic [COEF_W-1:0] dry_q;
        logic [GAIN_W-1:0] gain;
        logic              bypass;
        logic              mono;
    } cfg_t;

    typedef struct packed {
        op_t  op;
        logic load_in;
        logic load_out;
    } dp_cmd_t;

    // round(p * 65536 / 100) == floor((p * 16384 + 12) / 25)
    function automatic logic [COEF_W-1:0] pct_q16(input logic [PCT_W-1:0] p);
        logic [21:0] n;
        logic [44:0] t;
        n = {p, 14'd0} + 22'd12;
        t = 45'(n) * 45'(RECIP_25);
        pct_q16 = COEF_W'(t >> 27);
    endfunction

    // round((200 + 80 f) * 65536 / 10000) == floor(((5 + 2 f) * 32768 + 62) / 125)
    function automatic logic [COEF_W-1:0] smooth_coef(input logic [6:0] f);
        logic [8:0]  k;
        logic [23:0] n;
        logic [48:0] t;
        k = {1'b0, f, 1'b0} + 9'd5;
        n = {k, 15'd0} + 24'd62;
        t = 49'(n) * 49'(RECIP_125);
        smooth_coef = COEF_W'(t >> 31);
    endfunction

    // round((10000 - 45 b) * 65536 / 10000) == floor(((2000 - 9 b) * 4096 + 62) / 125)
    function automatic logic [COEF_W-1:0] bass_coef(input logic [6:0] b);
        logic [10:0] k;
        logic [23:0] n;
        logic [48:0] t;
        k = 11'd2000 - (11'(b) * 11'd9);
        n = {1'b0, k, 12'd0} + 24'd62;
        t = 49'(n) * 49'(RECIP_125);
        bass_coef = COEF_W'(t >> 31);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SAT_W-1:0] x
    );
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
        lo = ~hi;
        if (x > hi) begin
            sat_sample = SAMPLE_BITS'(hi);
        end else if (x < lo) begin
            sat_sample = SAMPLE_BITS'(lo);
        end else begin
            sat_sample = SAMPLE_BITS'(x);
        end
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] mag(input logic signed [SAMPLE_BITS-1:0] x);
        logic signed [SAMPLE_BITS:0] w;
        w = (SAMPLE_BITS + 1)'(x);
        if (w < 0) begin
            w = -w;
        end
        mag = SAMPLE_BITS'(w);
    endfunction

endpackage

// ===== hw/rtl/swe_cfg.sv =====
// ----------------------------------------------------------------------------
// swe_cfg - configuration registers (gain, bypass, mono stored raw)
// Converts the other writes into the Q.16 coefficients the datapath uses.
// ----------------------------------------------------------------------------
module swe_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [swe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swe_pkg::CFG_DATA_W-1:0]  cfg_data,
    output swe_pkg::cfg_t                   cfg
);
    import swe_pkg::*;

    localparam logic [PCT_W-1:0]  WIDTH_RST   = 8'd130;
    localparam logic [6:0]        ENHANCE_RST = 7'd35;
    localparam logic [6:0]        FOCUS_RST   = 7'd55;
    localparam logic [6:0]        BASS_RST    = 7'd30;
    localparam logic [GAIN_W-1:0] GAIN_RST    = 16'd8192;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [6:0] wet_sel;

    always_comb begin
        cfg_next = cfg_reg;
        wet_sel  = (cfg_data[6:0] > WET_MAX) ? WET_MAX : cfg_data[6:0];
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WIDTH:   cfg_next.width_q   = pct_q16(cfg_data[PCT_W-1:0]);
                REG_ENHANCE: cfg_next.enhance_q = pct_q16({1'b0, cfg_data[6:0]});
                REG_FOCUS:   cfg_next.smooth_q  = smooth_coef(cfg_data[6:0]);
                REG_BASS:    cfg_next.bass_q    = bass_coef(cfg_data[6:0]);
                REG_WET: begin
                    cfg_next.wet_q = pct_q16({1'b0, wet_sel});
                    cfg_next.dry_q = COEF_ONE - pct_q16({1'b0, wet_sel});
                end
                REG_GAIN:    cfg_next.gain      = cfg_data[GAIN_W-1:0];
                REG_BYPASS:  cfg_next.bypass    = cfg_data[0];
                REG_MONO:    cfg_next.mono      = cfg_data[0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width_q   <= pct_q16(WIDTH_RST);
            cfg_reg.enhance_q <= pct_q16({1'b0, ENHANCE_RST});
            cfg_reg.smooth_q  <= smooth_coef(FOCUS_RST);
            cfg_reg.bass_q    <= bass_coef(BASS_RST);
            cfg_reg.wet_q     <= COEF_ONE;
            cfg_reg.dry_q     <= '0;
            cfg_reg.gain      <= GAIN_RST;
            cfg_reg.bypass    <= 1'b0;
            cfg_reg.mono      <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/swe_dp.sv =====
// ----------------------------------------------------------------------------
// swe_dp - datapath
// Frame registers, one shared registered multiplier, smoother state,
// accumulators, peak holds and the result register.
// ----------------------------------------------------------------------------
module swe_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  swe_pkg::cfg_t                       cfg,
    input  swe_pkg::dp_cmd_t                    cmd,
    input  logic [2*swe_pkg::SAMPLE_BITS-1:0]   in_data,
    input  logic                                in_last,
    output logic [4*swe_pkg::SAMPLE_BITS-1:0]   out_data
);
    import swe_pkg::*;

    localparam logic signed [UPD_W-1:0] ST_HI =
        {{(UPD_W - STATE_BITS + 1){1'b0}}, {(STATE_BITS - 1){1'b1}}};
    localparam logic signed [UPD_W-1:0] ST_LO = ~ST_HI;

    logic signed [SAMPLE_BITS-1:0]  l_reg, l_next;
    logic signed [SAMPLE_BITS-1:0]  r_reg, r_next;
    logic signed [SAMPLE_BITS-1:0]  mid_reg, mid_next;
    logic signed [STATE_BITS-1:0]   sidef_reg, sidef_next;
    logic                           last_reg, last_next;
    logic signed [STATE_BITS-1:0]   state_reg, state_next;
    logic signed [MUL_P_W-1:0]      prod_reg, prod_next;
    logic signed [SUM_W-1:0]        acc_reg, acc_next;
    logic signed [SUM_W-1:0]        mixl_reg, mixl_next;
    logic signed [SUM_W-1:0]        mixr_reg, mixr_next;
    logic signed [MUL_A_W-1:0]      wl_reg, wl_next;
    logic signed [MUL_A_W-1:0]      wr_reg, wr_next;
    logic signed [SAMPLE_BITS-1:0]  resl_reg, resl_next;
    logic signed [SAMPLE_BITS-1:0]  resr_reg, resr_next;
    logic [SAMPLE_BITS-1:0]         inpk_reg, inpk_next;
    logic [SAMPLE_BITS-1:0]         outpk_reg, outpk_next;
    logic [4*SAMPLE_BITS-1:0]       out_reg, out_next;

    logic signed [SAMPLE_BITS-1:0]  in_l, in_r;
    logic signed [SAMPLE_BITS:0]    pair_sum, pair_dif;
    logic signed [SAMPLE_BITS-1:0]  side;
    logic [SAMPLE_BITS-1:0]         in_mag, inpk_new;
    logic [SAMPLE_BITS-1:0]         res_mag, opk_cand, outpk_new;
    logic signed [STATE_BITS:0]     diff;
    logic signed [UPD_W-1:0]        upd;
    logic signed [MUL_A_W-1:0]      sd;
    logic signed [MUL_A_W-1:0]      mul_a;
    logic signed [MUL_B_W-1:0]      mul_b;
    logic signed [MUL_B_W-1:0]      b_gain;

    always_comb begin
        in_l     = in_data[SAMPLE_BITS-1:0];
        in_r     = cfg.mono ? '0 : in_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
        pair_sum = (SAMPLE_BITS + 1)'(in_l) + (SAMPLE_BITS + 1)'(in_r);
        pair_dif = (SAMPLE_BITS + 1)'(in_l) - (SAMPLE_BITS + 1)'(in_r);
        side     = SAMPLE_BITS'(pair_dif >>> 1);
        in_mag   = (mag(in_r) > mag(in_l)) ? mag(in_r) : mag(in_l);
        inpk_new = (in_mag > inpk_reg) ? in_mag : inpk_reg;

        res_mag   = (mag(resr_reg) > mag(resl_reg)) ? mag(resr_reg) : mag(resl_reg);
        opk_cand  = cfg.bypass ? inpk_reg : res_mag;
        outpk_new = (opk_cand > outpk_reg) ? opk_cand : outpk_reg;

        diff   = (STATE_BITS + 1)'(sidef_reg) - (STATE_BITS + 1)'(state_reg);
        upd    = UPD_W'(prod_reg >>> Q_SHIFT) + UPD_W'(state_reg);
        sd     = MUL_A_W'(prod_reg >>> (Q_SHIFT + FRAC));
        b_gain = $signed(MUL_B_W'(cfg.gain));
    end

    always_comb begin
        l_next     = l_reg;
        r_next     = r_reg;
        mid_next   = mid_reg;
        sidef_next = sidef_reg;
        last_next  = last_reg;
        state_next = state_reg;
        acc_next   = acc_reg;
        mixl_next  = mixl_reg;
        mixr_next  = mixr_reg;
        wl_next    = wl_reg;
        wr_next    = wr_reg;
        resl_next  = resl_reg;
        resr_next  = resr_reg;
        inpk_next  = inpk_reg;
        outpk_next = outpk_reg;
        out_next   = out_reg;
        mul_a      = '0;
        mul_b      = '0;

        if (cmd.load_in) begin
            l_next     = in_l;
            r_next     = in_r;
            mid_next   = SAMPLE_BITS'(pair_sum >>> 1);
            sidef_next = STATE_BITS'(side) <<< FRAC;
            last_next  = in_last;
            resl_next  = in_l;
            resr_next  = in_r;
            inpk_next  = inpk_new;
        end

        unique case (cmd.op)
            OP_NONE: begin
            end
            OP_DIFF: begin
                mul_a = MUL_A_W'(diff);
                mul_b = $signed({1'b0, cfg.smooth_q});
            end
            OP_UPD: begin
                if (upd > ST_HI) begin
                    state_next = STATE_BITS'(ST_HI);
                end else if (upd < ST_LO) begin
                    state_next = STATE_BITS'(ST_LO);
                end else begin
                    state_next = STATE_BITS'(upd);
                end
                mul_a = MUL_A_W'(sidef_reg);
                mul_b = $signed({1'b0, cfg.width_q});
            end
            OP_HP: begin
                acc_next = SUM_W'(prod_reg);
                mul_a    = MUL_A_W'(diff);
                mul_b    = $signed({1'b0, cfg.enhance_q});
            end
            OP_ACC: begin
                acc_next = acc_reg + SUM_W'(prod_reg);
                mul_a    = MUL_A_W'(l_reg);
                mul_b    = $signed({1'b0, cfg.dry_q});
            end
            OP_SCL: begin
                mixl_next = SUM_W'(prod_reg);
                mul_a     = MUL_A_W'(acc_reg >>> Q_SHIFT);
                mul_b     = $signed({1'b0, cfg.bass_q});
            end
            OP_SIDE: begin
                wl_next = MUL_A_W'(mid_reg) + sd;
                wr_next = MUL_A_W'(mid_reg) - sd;
                mul_a   = MUL_A_W'(r_reg);
                mul_b   = $signed({1'b0, cfg.dry_q});
            end
            OP_MIXR: begin
                mixr_next = SUM_W'(prod_reg);
                mul_a     = wl_reg;
                mul_b     = $signed({1'b0, cfg.wet_q});
            end
            OP_WL: begin
                mixl_next = mixl_reg + SUM_W'(prod_reg);
                mul_a     = wr_reg;
                mul_b     = $signed({1'b0, cfg.wet_q});
            end
            OP_WR: begin
                mixr_next = mixr_reg + SUM_W'(prod_reg);
                mul_a     = MUL_A_W'(mixl_reg >>> Q_SHIFT);
                mul_b     = b_gain;
            end
            OP_GL: begin
                resl_next = sat_sample(SAT_W'(prod_reg >>> GAIN_SHIFT));
                mul_a     = MUL_A_W'(mixr_reg >>> Q_SHIFT);
                mul_b     = b_gain;
            end
            OP_GR: begin
                resr_next = sat_sample(SAT_W'(prod_reg >>> GAIN_SHIFT));
            end
            OP_MMUL: begin
                mul_a = MUL_A_W'(l_reg);
                mul_b = b_gain;
            end
            OP_MSAT: begin
                resl_next = sat_sample(SAT_W'(prod_reg >>> GAIN_SHIFT));
                resr_next = '0;
            end
            default: begin
            end
        endcase

        if (cmd.load_out) begin
            out_next   = {outpk_new, inpk_reg, resr_reg, resl_reg};
            outpk_next = last_reg ? '0 : outpk_new;
            if (last_reg) begin
                inpk_next = '0;
            end
        end

        prod_next = mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            inpk_reg  <= '0;
            outpk_reg <= '0;
        end else begin
            state_reg <= state_next;
            inpk_reg  <= inpk_next;
            outpk_reg <= outpk_next;
        end
    end

    always_ff @(posedge aclk) begin
        l_reg     <= l_next;
        r_reg     <= r_next;
        mid_reg   <= mid_next;
        sidef_reg <= sidef_next;
        last_reg  <= last_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        mixl_reg  <= mixl_next;
        mixr_reg  <= mixr_next;
        wl_reg    <= wl_next;
        wr_reg    <= wr_next;
        resl_reg  <= resl_next;
        resr_reg  <= resr_next;
        out_reg   <= out_next;
    end

    assign out_data = out_reg;

endmodule

// ===== hw/rtl/swe_ctrl.sv =====
// ----------------------------------------------------------------------------
// swe_ctrl - frame sequencer
// Accepts one frame, steps the datapath through its stereo or mono multiply
// schedule (none in bypass) and hands the result to the output register.
// ----------------------------------------------------------------------------
module swe_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  swe_pkg::cfg_t     cfg,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output swe_pkg::dp_cmd_t  cmd
);
    import swe_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_S1   = 4'd1;
    localparam logic [3:0] ST_S2   = 4'd2;
    localparam logic [3:0] ST_S3   = 4'd3;
    localparam logic [3:0] ST_S4   = 4'd4;
    localparam logic [3:0] ST_S5   = 4'd5;
    localparam logic [3:0] ST_S6   = 4'd6;
    localparam logic [3:0] ST_S7   = 4'd7;
    localparam logic [3:0] ST_S8   = 4'd8;
    localparam logic [3:0] ST_S9   = 4'd9;
    localparam logic [3:0] ST_S10  = 4'd10;
    localparam logic [3:0] ST_S11  = 4'd11;
    localparam logic [3:0] ST_M1   = 4'd12;
    localparam logic [3:0] ST_M2   = 4'd13;
    localparam logic [3:0] ST_FIN  = 4'd14;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.op       = OP_NONE;
        out_free     = !m_valid_reg || m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    if (cfg.bypass) begin
                        state_next = ST_FIN;
                    end else if (cfg.mono) begin
                        state_next = ST_M1;
                    end else begin
                        state_next = ST_S1;
                    end
                end
            end
            ST_S1:  begin cmd.op = OP_DIFF; state_next = ST_S2;  end
            ST_S2:  begin cmd.op = OP_UPD;  state_next = ST_S3;  end
            ST_S3:  begin cmd.op = OP_HP;   state_next = ST_S4;  end
            ST_S4:  begin cmd.op = OP_ACC;  state_next = ST_S5;  end
            ST_S5:  begin cmd.op = OP_SCL;  state_next = ST_S6;  end
            ST_S6:  begin cmd.op = OP_SIDE; state_next = ST_S7;  end
            ST_S7:  begin cmd.op = OP_MIXR; state_next = ST_S8;  end
            ST_S8:  begin cmd.op = OP_WL;   state_next = ST_S9;  end
            ST_S9:  begin cmd.op = OP_WR;   state_next = ST_S10; end
            ST_S10: begin cmd.op = OP_GL;   state_next = ST_S11; end
            ST_S11: begin cmd.op = OP_GR;   state_next = ST_FIN; end
            ST_M1:  begin cmd.op = OP_MMUL; state_next = ST_M2;  end
            ST_M2:  begin cmd.op = OP_MSAT; state_next = ST_FIN; end
            ST_FIN: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg != ST_IDLE)
        else $error("accepted transaction did not start a frame");

    a_bypass_direct: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && cfg.bypass |=> state_reg == ST_FIN)
        else $error("bypass frame did not go straight to finish");

    a_valid_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_FIN)
        else $error("result raised outside finish step");

    a_fin_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) && m_tvalid && !m_tready |=> state_reg == ST_FIN)
        else $error("finish step left while result register full");
`endif

endmodule

// ===== hw/rtl/stereo_width_enhancer_top.sv =====
// ----------------------------------------------------------------------------
// stereo_width_enhancer_top - mid/side stereo widener, one frame per transaction
// In stereo mode, splits each frame into mid and side, smooths and enhances the side,
// mixes dry/wet and applies output gain; every mode tracks per-block peaks.
//
//   channel  dir  handshake            payload
//   s_       in   s_tvalid/s_tready    s_tdata, s_tlast (block end)
//   m_       out  m_tvalid/m_tready    m_tdata
//   cfg_     in   cfg_wr_en            cfg_index, cfg_data
//
// Stereo: eleven steps issue ten products to the one shared 36x19 multiplier,
// then one finish step. Mono: steps M1 and M2, then the finish step.
// Bypass: straight from accept to the finish step.
// One frame in flight; the next is accepted once the result is in the output register.
// A stalled output holds the sequencer in its finish step, and the input with it.
// Synchronous active-low reset restores register defaults, clears smoother and peaks.
// ----------------------------------------------------------------------------
module stereo_width_enhancer_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [2*swe_pkg::SAMPLE_BITS-1:0]   s_tdata,   // left_sample, right_sample
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [4*swe_pkg::SAMPLE_BITS-1:0]   m_tdata,   // left_out, right_out, in_peak, out_peak
    input  logic                                cfg_wr_en,
    input  logic [swe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [swe_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import swe_pkg::*;

    cfg_t    cfg;
    dp_cmd_t cmd;

    swe_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    swe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    swe_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .in_data  (s_tdata),
        .in_last  (s_tlast),
        .out_data (m_tdata)
    );

endmodule
